@@ rtl/diff_drive_odometry_core_assert.svh @@
// Assertion macros shared by the odometry RTL.
// DDOC_ASSERT expects aclk and aresetn in scope and is disabled in reset.
// DDOC_ASSERT_ALWAYS is also checked while reset is applied.
`ifndef DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DDOC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("odometry assertion failed");
`define DDOC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("odometry assertion failed");
`else
`define DDOC_ASSERT(lbl, prop)
`define DDOC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/odo_pkg.sv @@
`default_nettype none

package odo_pkg;

    // shared serial arithmetic unit
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  cnt;
    } alu_cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
    localparam logic [1:0] REG_WHEEL_BASE   = 2'd1;

    localparam logic [19:0] RADIUS_RST = 20'd75000;
    localparam logic [21:0] BASE_RST   = 22'd420000;

    // arithmetic constants
    localparam logic [63:0] PI_Q24     = 64'd52707179;
    localparam logic [63:0] RIM_DEN    = 64'd8053063680;
    localparam logic [63:0] TURN_K_Q32 = 64'd44798134;
    localparam logic [63:0] MRAD_SCALE = 64'd1000;
    localparam logic [63:0] US_PER_S   = 64'd1000000;
    localparam logic [63:0] HALF_2P43  = 64'h0000_0800_0000_0000;
    localparam logic [63:0] HALF_2P24  = 64'd8388608;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 32;

    localparam logic signed [41:0] POS_HI = 42'sd549755813887;
    localparam logic signed [41:0] POS_LO = -42'sd549755813888;
    localparam logic signed [39:0] POS_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN = 40'sh80_0000_0000;
    localparam logic signed [23:0] ANG_MAX = 24'sh7F_FFFF;
    localparam logic signed [23:0] ANG_MIN = 24'sh80_0000;

    // atan(2^-i) in Q30, 2^30 = pi/2
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/odo_alu.sv @@
`default_nettype none

`include "diff_drive_odometry_core_assert.svh"

// Bit-serial unsigned multiply (shift-add) and rounding divide (restoring).
module odo_alu
    import odo_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire alu_cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output logic [63:0]      result
);

    logic        busy_reg;
    logic        done_reg;
    logic        op_reg;
    logic [6:0]  cnt_reg;
    logic [64:0] acc_reg;
    logic [63:0] sh_reg;
    logic [63:0] mp_reg;

    logic [64:0] rem_sh;
    logic        rem_ge;
    logic [63:0] acc_sum;

    // one multiplier bit or one quotient bit per cycle
    assign rem_sh  = {acc_reg[63:0], sh_reg[63]};
    assign rem_ge  = rem_sh >= {1'b0, mp_reg};
    assign acc_sum = acc_reg[63:0] + sh_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.cnt;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg  <= cmd.op;
            acc_reg <= '0;
            mp_reg  <= cmd.b;
            sh_reg  <= (cmd.op == OP_MUL) ? cmd.a : cmd.a + (cmd.b >> 1);
        end else if (busy_reg) begin
            if (op_reg == OP_MUL) begin
                if (mp_reg[0]) begin
                    acc_reg <= {1'b0, acc_sum};
                end
                sh_reg <= {sh_reg[62:0], 1'b0};
                mp_reg <= {1'b0, mp_reg[63:1]};
            end else begin
                acc_reg <= rem_ge ? rem_sh - {1'b0, mp_reg} : rem_sh;
                sh_reg  <= {sh_reg[62:0], rem_ge};
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = (op_reg == OP_MUL) ? acc_reg[63:0] : sh_reg;

    `DDOC_ASSERT_ALWAYS(a_done_not_busy, done_reg |-> !busy_reg)
    `DDOC_ASSERT(a_last_bit_done, busy_reg && cnt_reg == 7'd1 && !start |=> done_reg)
    `DDOC_ASSERT(a_no_restart, start |-> !busy_reg)

endmodule

`default_nettype wire

@@ rtl/odo_cordic.sv @@
`default_nettype none

// Rotation-mode CORDIC, one micro-rotation per cycle, Q30 angle and vector.
module odo_cordic
    import odo_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [15:0]        ang,
    output logic                    done,
    output logic signed [17:0]      cos_q16,
    output logic signed [17:0]      sin_q16
);

    localparam int NSTEP = (STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX : STEPS;

    logic                run_reg;
    logic                done_reg;
    logic [5:0]          step_reg;
    logic                flip_reg;
    logic signed [33:0]  x_reg;
    logic signed [33:0]  y_reg;
    logic signed [33:0]  z_reg;

    logic [4:0]          idx;
    logic signed [33:0]  xs;
    logic signed [33:0]  ys;
    logic signed [33:0]  at;
    logic signed [15:0]  ang_s;
    logic                flip_w;
    logic [15:0]         ang_fold;

    assign idx = step_reg[4:0];
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;
    assign at  = $signed({2'b00, atan_q30(idx)});

    // fold the far half-plane by pi, negate at the end
    assign ang_s    = ang;
    assign flip_w   = (ang_s > 16'sd16384) || (ang_s < -16'sd16384);
    assign ang_fold = flip_w ? ang + 16'h8000 : ang;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(NSTEP - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            flip_reg <= flip_w;
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= $signed({{2{ang_fold[15]}}, ang_fold, 16'h0000});
        end else if (run_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    // Q30 to Q16, rounding half away from zero, then undo the fold
    function automatic logic signed [17:0] to_q16(input logic signed [33:0] v,
                                                  input logic flip);
        logic [33:0] mag;
        logic [33:0] r;
        logic [17:0] m18;
        mag = v[33] ? 34'(-v) : 34'(v);
        r   = (mag + 34'd8192) >> 14;
        m18 = r[17:0];
        return (v[33] ^ flip) ? $signed(-m18) : $signed(m18);
    endfunction

    assign done    = done_reg;
    assign cos_q16 = to_q16(x_reg, flip_reg);
    assign sin_q16 = to_q16(y_reg, flip_reg);

endmodule

`default_nettype wire

@@ rtl/diff_drive_odometry_core.sv @@
`default_nettype none

`include "diff_drive_odometry_core_assert.svh"

// Each transaction runs through the bit-serial multiply/divide unit and the CORDIC in turn;
//   with a zero wheel base the heading and angular speed steps are skipped.
// A new transaction is taken only once the sequencer is back in idle; a finished result
//   waits on m_tready while the output register still holds the previous one.
// Reset (aresetn low, synchronous): pose cleared, registers back to 75000 / 420000 um.
module diff_drive_odometry_core
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [21:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // left_rpm[15:0], right_rpm[31:16], dt_us[51:32], zero pad
    input  wire logic [55:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x_um[39:0], pos_y_um[79:40], heading[95:80], lin_speed_um_s[127:96],
    // ang_speed_mrad_s[151:128]
    output logic [151:0]      m_tdata
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LMUL1 = 5'd1;
    localparam logic [4:0] ST_LMUL2 = 5'd2;
    localparam logic [4:0] ST_LDIV  = 5'd3;
    localparam logic [4:0] ST_RMUL1 = 5'd4;
    localparam logic [4:0] ST_RMUL2 = 5'd5;
    localparam logic [4:0] ST_RDIV  = 5'd6;
    localparam logic [4:0] ST_TMUL  = 5'd7;
    localparam logic [4:0] ST_TDIV  = 5'd8;
    localparam logic [4:0] ST_KMUL  = 5'd9;
    localparam logic [4:0] ST_AMUL  = 5'd10;
    localparam logic [4:0] ST_ADIV  = 5'd11;
    localparam logic [4:0] ST_CORD  = 5'd12;
    localparam logic [4:0] ST_DMUL  = 5'd13;
    localparam logic [4:0] ST_DDIV  = 5'd14;
    localparam logic [4:0] ST_XMUL  = 5'd15;
    localparam logic [4:0] ST_YMUL  = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;

    logic [4:0]          state_reg;
    logic                pend_reg;
    logic [19:0]         rad_reg;
    logic [21:0]         base_reg;
    logic signed [39:0]  pose_x_reg;
    logic signed [39:0]  pose_y_reg;
    logic [15:0]         heading_reg;
    logic                m_tvalid_reg;
    logic [151:0]        m_tdata_reg;

    logic signed [15:0]  l_reg;
    logic signed [15:0]  r_reg;
    logic [19:0]         dt_reg;
    logic [63:0]         m_reg;
    logic signed [29:0]  vl_reg;
    logic signed [29:0]  vr_reg;
    logic [63:0]         q_reg;
    logic signed [23:0]  ang_reg;
    logic [39:0]         d_reg;

    alu_cmd_t            alu_cmd;
    logic                alu_start;
    logic                alu_busy;
    logic                alu_done;
    logic [63:0]         alu_res;
    logic                cord_start;
    logic                cord_done;
    logic signed [17:0]  cos_w;
    logic signed [17:0]  sin_w;

    logic [15:0]         l_mag;
    logic [15:0]         r_mag;
    logic signed [30:0]  sum_w;
    logic signed [30:0]  diff_w;
    logic [30:0]         sum_mag;
    logic [30:0]         diff_mag;
    logic [29:0]         lin_mag;
    logic signed [31:0]  lin_w;
    logic [17:0]         cos_mag;
    logic [17:0]         sin_mag;
    logic [63:0]         turn_t;
    logic [63:0]         trav_r;
    logic [39:0]         trav_q;
    logic signed [41:0]  trav_x;
    logic signed [41:0]  trav_y;
    logic signed [29:0]  v_div;

    // magnitudes and signs of the operands
    assign l_mag    = l_reg[15] ? 16'(-l_reg) : 16'(l_reg);
    assign r_mag    = r_reg[15] ? 16'(-r_reg) : 16'(r_reg);
    assign sum_w    = 31'(vl_reg) + 31'(vr_reg);
    assign diff_w   = 31'(vr_reg) - 31'(vl_reg);
    assign sum_mag  = sum_w[30] ? 31'(-sum_w) : 31'(sum_w);
    assign diff_mag = diff_w[30] ? 31'(-diff_w) : 31'(diff_w);
    assign lin_mag  = 30'((sum_mag + 31'd1) >> 1);
    assign lin_w    = sum_w[30] ? -$signed({2'b00, lin_mag}) : $signed({2'b00, lin_mag});
    assign cos_mag  = cos_w[17] ? 18'(-cos_w) : 18'(cos_w);
    assign sin_mag  = sin_w[17] ? 18'(-sin_w) : 18'(sin_w);

    // heading step is bits 59:44 of the rounded Q44 product
    assign turn_t = alu_res + HALF_2P43;

    // travel component, rounded from Q24
    assign trav_r = (alu_res + HALF_2P24) >> 24;
    assign trav_q = trav_r[39:0];
    assign trav_x = (sum_w[30] ^ cos_w[17]) ? -$signed({2'b00, trav_q})
                                            : $signed({2'b00, trav_q});
    assign trav_y = (sum_w[30] ^ sin_w[17]) ? -$signed({2'b00, trav_q})
                                            : $signed({2'b00, trav_q});

    // rim speed from the divider, signed by the wheel direction
    assign v_div = ((state_reg == ST_LDIV) ? l_reg[15] : r_reg[15])
                 ? -$signed(alu_res[29:0]) : $signed(alu_res[29:0]);

    function automatic logic signed [39:0] sat_add(input logic signed [39:0] p,
                                                   input logic signed [41:0] dv);
        logic signed [41:0] s;
        s = 42'(p) + dv;
        if (s > POS_HI) begin
            return POS_MAX;
        end else if (s < POS_LO) begin
            return POS_MIN;
        end
        return s[39:0];
    endfunction

    function automatic logic signed [23:0] ang_sat(input logic [63:0] mag,
                                                   input logic neg);
        if (neg) begin
            if (mag > 64'd8388608) begin
                return ANG_MIN;
            end
            return $signed(-mag[23:0]);
        end
        if (mag > 64'd8388607) begin
            return ANG_MAX;
        end
        return $signed(mag[23:0]);
    endfunction

    // operation issued in each sequencer step
    always_comb begin
        alu_cmd = '0;
        unique case (state_reg)
            ST_LMUL1: alu_cmd = '{OP_MUL, 64'(l_mag), 64'(rad_reg), 7'd20};
            ST_LMUL2: alu_cmd = '{OP_MUL, m_reg, PI_Q24, 7'd26};
            ST_LDIV:  alu_cmd = '{OP_DIV, m_reg, RIM_DEN, 7'd64};
            ST_RMUL1: alu_cmd = '{OP_MUL, 64'(r_mag), 64'(rad_reg), 7'd20};
            ST_RMUL2: alu_cmd = '{OP_MUL, m_reg, PI_Q24, 7'd26};
            ST_RDIV:  alu_cmd = '{OP_DIV, m_reg, RIM_DEN, 7'd64};
            ST_TMUL:  alu_cmd = '{OP_MUL, 64'(diff_mag), 64'(dt_reg), 7'd20};
            ST_TDIV:  alu_cmd = '{OP_DIV, m_reg << 12, 64'(base_reg), 7'd64};
            ST_KMUL:  alu_cmd = '{OP_MUL, q_reg, TURN_K_Q32, 7'd26};
            ST_AMUL:  alu_cmd = '{OP_MUL, 64'(diff_mag), MRAD_SCALE, 7'd10};
            ST_ADIV:  alu_cmd = '{OP_DIV, m_reg, 64'(base_reg), 7'd64};
            ST_DMUL:  alu_cmd = '{OP_MUL, 64'(lin_mag) << 8, 64'(dt_reg), 7'd20};
            ST_DDIV:  alu_cmd = '{OP_DIV, m_reg, US_PER_S, 7'd64};
            ST_XMUL:  alu_cmd = '{OP_MUL, 64'(d_reg), 64'(cos_mag), 7'd18};
            ST_YMUL:  alu_cmd = '{OP_MUL, 64'(d_reg), 64'(sin_mag), 7'd18};
            default:  alu_cmd = '0;
        endcase
    end

    assign alu_start  = !pend_reg && state_reg != ST_IDLE && state_reg != ST_CORD
                        && state_reg != ST_OUT;
    assign cord_start = !pend_reg && state_reg == ST_CORD;

    // sequencer, pose and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            rad_reg      <= RADIUS_RST;
            base_reg     <= BASE_RST;
            pose_x_reg   <= '0;
            pose_y_reg   <= '0;
            heading_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_WHEEL_RADIUS: rad_reg <= cfg_wdata[19:0];
                    REG_WHEEL_BASE:   base_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (alu_start || cord_start) begin
                pend_reg <= 1'b1;
            end
            if (alu_done || cord_done) begin
                pend_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:  if (s_tvalid) state_reg <= ST_LMUL1;
                ST_LMUL1: if (alu_done) state_reg <= ST_LMUL2;
                ST_LMUL2: if (alu_done) state_reg <= ST_LDIV;
                ST_LDIV:  if (alu_done) state_reg <= ST_RMUL1;
                ST_RMUL1: if (alu_done) state_reg <= ST_RMUL2;
                ST_RMUL2: if (alu_done) state_reg <= ST_RDIV;
                ST_RDIV: begin
                    if (alu_done) begin
                        state_reg <= (base_reg != '0) ? ST_TMUL : ST_CORD;
                    end
                end
                ST_TMUL:  if (alu_done) state_reg <= ST_TDIV;
                ST_TDIV:  if (alu_done) state_reg <= ST_KMUL;
                ST_KMUL: begin
                    if (alu_done) begin
                        heading_reg <= heading_reg + turn_t[59:44];
                        state_reg   <= ST_AMUL;
                    end
                end
                ST_AMUL:  if (alu_done) state_reg <= ST_ADIV;
                ST_ADIV:  if (alu_done) state_reg <= ST_CORD;
                ST_CORD:  if (cord_done) state_reg <= ST_DMUL;
                ST_DMUL:  if (alu_done) state_reg <= ST_DDIV;
                ST_DDIV:  if (alu_done) state_reg <= ST_XMUL;
                ST_XMUL: begin
                    if (alu_done) begin
                        pose_x_reg <= sat_add(pose_x_reg, trav_x);
                        state_reg  <= ST_YMUL;
                    end
                end
                ST_YMUL: begin
                    if (alu_done) begin
                        pose_y_reg <= sat_add(pose_y_reg, trav_y);
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // operand and intermediate registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            l_reg   <= s_tdata[15:0];
            r_reg   <= s_tdata[31:16];
            dt_reg  <= s_tdata[51:32];
            ang_reg <= '0;
        end
        if (alu_done) begin
            m_reg <= alu_res;
        end
        if (alu_done && state_reg == ST_LDIV) begin
            vl_reg <= v_div;
        end
        if (alu_done && state_reg == ST_RDIV) begin
            vr_reg <= v_div;
        end
        if (alu_done && state_reg == ST_TDIV) begin
            q_reg <= diff_w[30] ? -alu_res : alu_res;
        end
        if (alu_done && state_reg == ST_ADIV) begin
            ang_reg <= ang_sat(alu_res, diff_w[30]);
        end
        if (alu_done && state_reg == ST_DDIV) begin
            d_reg <= alu_res[39:0];
        end
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {ang_reg, lin_w, heading_reg, pose_y_reg, pose_x_reg};
        end
    end

    odo_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .cmd     (alu_cmd),
        .busy    (alu_busy),
        .done    (alu_done),
        .result  (alu_res)
    );

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .ang     (heading_reg),
        .done    (cord_done),
        .cos_q16 (cos_w),
        .sin_q16 (sin_w)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `DDOC_ASSERT(a_alu_done_pending, alu_done |-> pend_reg)
    `DDOC_ASSERT(a_idle_alu_quiet, state_reg == ST_IDLE |-> !alu_busy)
    `DDOC_ASSERT(a_cordic_in_step, cord_done |-> state_reg == ST_CORD)

endmodule

`default_nettype wire
